// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, character codes, register indexes and defaults for the
// text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int TCW_COLUMNS  = 80;
   localparam int TCW_ROWS     = 25;

   localparam int CHAR_W       = 8;
   localparam int COLOR_W      = 8;
   localparam int CELL_W       = 16;
   localparam int COL_FIELD_W  = 7;
   localparam int ROW_FIELD_W  = 5;
   localparam int CADDR_W      = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_BACK    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_DEL     = 8'd127;

   localparam logic [CELL_W-1:0]  BLANK_RESET = 16'h0720;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

   localparam logic [CSR_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_EN  = 1'd1;

endpackage

// ----- hdl/tcw_ifs.sv -----
// ----------------------------------------------------------------------------
// tcw request and response channels
// Valid/ready channels carrying console commands and their results.
// ----------------------------------------------------------------------------
interface tcw_req_if
   import tcw_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [CHAR_W-1:0]      char_code;
   logic [COL_FIELD_W-1:0] read_col;
   logic [ROW_FIELD_W-1:0] read_row;

   modport source (output valid, op, char_code, read_col, read_row, input ready);
   modport sink   (input valid, op, char_code, read_col, read_row, output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CELL_W-1:0]      cell_data;
   logic [COL_FIELD_W-1:0] cur_col;
   logic [ROW_FIELD_W-1:0] cur_row;
   logic [CADDR_W-1:0]     cursor_addr;
   logic                   cursor_update;

   modport source (output valid, cell_data, cur_col, cur_row, cursor_addr, cursor_update,
                   input ready);
   modport sink   (input valid, cell_data, cur_col, cur_row, cursor_addr, cursor_update,
                   output ready);
endinterface

// ----- hdl/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console engine: screen store of character/attribute cells with a
// cursor, line wrap, newline blanking, backspace, return and ring scrolling.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_     in         op, char_code, read_col, read_row
//  rsp_     out        cell_data, cur_col, cur_row, cursor_addr, cursor_update
//  csr_     in         csr_we, csr_index, csr_wdata (write only)
//
//  read, cr, backspace: exec then resp; printable: the same, plus a row of
//  blanking on scroll; newline: blanks from the cursor to the row end, plus a row
//  on scroll; the blanking runs one cell write per cycle through the single ram write port
//  after reset a clear pass writes ROWS * 2**clog2(COLUMNS) cells (3200 at
//  80x25) before req_chan.ready rises
//  a finished beat waits in the output register; the next req beat is taken
// ----------------------------------------------------------------------------
module text_console_char_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_chan,
   tcw_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = ROWS * (1 << COL_W);

   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [COL_FIELD_W:0] COLS_LIM = (COL_FIELD_W+1)'(COLUMNS);
   localparam logic [ROW_FIELD_W:0] ROWS_LIM = (ROW_FIELD_W+1)'(ROWS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_BLANK = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [ROW_W-1:0]        top_ff, top_in;
   logic                    adv_ff, adv_in;
   logic                    upd_ff, upd_in;
   logic                    hit_ff, hit_in;
   logic [COLOR_W-1:0]      color_ff;
   logic                    cur_en_ff;

   logic                    op_ff;
   logic [CHAR_W-1:0]       ch_ff;
   logic [COL_FIELD_W-1:0]  rc_ff;
   logic [ROW_FIELD_W-1:0]  rr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       cell_ff;
   logic [COL_FIELD_W-1:0]  cur_col_ff;
   logic [ROW_FIELD_W-1:0]  cur_row_ff;
   logic [CADDR_W-1:0]      caddr_ff;
   logic                    cupd_ff;

   logic                    req_fire;
   logic                    rsp_load;
   logic                    rd_in_range;
   logic [ROW_W-1:0]        top_next;
   logic [ROW_W-1:0]        unit_row;
   logic [COL_W-1:0]        unit_col;
   logic [ADDR_W-1:0]       unit_addr;
   logic                    ram_we;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [CELL_W-1:0]       ram_wdata;
   logic [CELL_W-1:0]       ram_rdata;
   logic [12:0]             lin_addr;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   assign rd_in_range = ({1'b0, rc_ff} < COLS_LIM) && ({1'b0, rr_ff} < ROWS_LIM);
   assign top_next    = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
   assign unit_row    = (op_ff == OP_READ) ? rr_ff[ROW_W-1:0] : row_ff;
   assign unit_col    = (op_ff == OP_READ) ? rc_ff[COL_W-1:0] : col_ff;
   assign lin_addr    = 13'(row_ff) * 13'(COLUMNS) + 13'(col_ff);

   tcw_addr_unit #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_addr (
      .top_row (top_ff),
      .vis_row (unit_row),
      .col     (unit_col),
      .addr    (unit_addr)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (unit_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      top_in    = top_ff;
      adv_in    = adv_ff;
      upd_in    = upd_ff;
      hit_in    = hit_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = unit_addr;
      ram_wdata = {color_ff, CH_SPACE};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = BLANK_RESET;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
               upd_in   = 1'b0;
               hit_in   = 1'b0;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_READ) begin
               ram_re   = rd_in_range;
               hit_in   = rd_in_range;
               state_in = ST_RESP;
            end else begin
               unique case (ch_ff) inside
                  CH_NEWLINE: begin
                     adv_in   = 1'b1;
                     state_in = ST_BLANK;
                  end
                  CH_BACK, CH_DEL: begin
                     col_in   = (col_ff == '0) ? '0 : col_ff - 1'b1;
                     state_in = ST_RESP;
                  end
                  CH_RETURN: begin
                     col_in   = '0;
                     state_in = ST_RESP;
                  end
                  default: begin
                     ram_we    = 1'b1;
                     ram_wdata = {color_ff, ch_ff};
                     upd_in    = cur_en_ff;
                     state_in  = ST_RESP;
                     if (col_ff == COL_LAST) begin
                        col_in = '0;
                        if (row_ff == ROW_LAST) begin
                           top_in   = top_next;
                           adv_in   = 1'b0;
                           state_in = ST_BLANK;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_BLANK: begin
            ram_we = 1'b1;
            if (col_ff == COL_LAST) begin
               col_in   = '0;
               state_in = ST_RESP;
               if (adv_ff) begin
                  if (row_ff == ROW_LAST) begin
                     top_in   = top_next;
                     adv_in   = 1'b0;
                     state_in = ST_BLANK;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         adv_ff       <= 1'b0;
         upd_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         adv_ff       <= adv_in;
         upd_ff       <= upd_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff  <= COLOR_RESET;
         cur_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TEXT_COLOR: color_ff  <= csr_wdata;
            REG_CURSOR_EN:  cur_en_ff <= csr_wdata[0];
            default: begin
               color_ff <= color_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_chan.op;
         ch_ff <= req_chan.char_code;
         rc_ff <= req_chan.read_col;
         rr_ff <= req_chan.read_row;
      end
      if (rsp_load) begin
         cell_ff    <= hit_ff ? ram_rdata : '0;
         cur_col_ff <= COL_FIELD_W'(col_ff);
         cur_row_ff <= ROW_FIELD_W'(row_ff);
         caddr_ff   <= lin_addr[CADDR_W-1:0];
         cupd_ff    <= upd_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cell_data     = cell_ff;
   assign rsp_chan.cur_col       = cur_col_ff;
   assign rsp_chan.cur_row       = cur_row_ff;
   assign rsp_chan.cursor_addr   = caddr_ff;
   assign rsp_chan.cursor_update = cupd_ff;

   a_fire_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted beat not taken into execution");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COL_LAST) && (row_ff <= ROW_LAST) && (top_ff <= ROW_LAST))
      else $error("cursor or ring offset out of range");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> !ram_we)
      else $error("screen write outside command execution");

   a_upd_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.cursor_update) |-> rsp_chan.cell_data == '0)
      else $error("cursor update reported with cell data");

endmodule

// ----- hdl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/tcw_addr_unit.sv -----
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Maps a visible row and column to a screen store address through the
// ring row offset.
// ----------------------------------------------------------------------------
module tcw_addr_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = TCW_COLUMNS,
   parameter int ROWS    = TCW_ROWS
) (
   input  logic [$clog2(ROWS)-1:0]                  top_row,
   input  logic [$clog2(ROWS)-1:0]                  vis_row,
   input  logic [$clog2(COLUMNS)-1:0]               col,
   output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]  addr
);
   localparam int ROW_W = $clog2(ROWS);
   localparam logic [ROW_W:0] ROWS_LIM = (ROW_W+1)'(ROWS);

   logic [ROW_W:0]   sum;
   logic [ROW_W:0]   ring;

   assign sum  = {1'b0, top_row} + {1'b0, vis_row};
   assign ring = (sum >= ROWS_LIM) ? sum - ROWS_LIM : sum;
   assign addr = {ring[ROW_W-1:0], col};
endmodule
